// ----- rtl/ise_pkg.sv -----
// shared types and constants for the insertion series engine
package ise_pkg;

  // fixed field widths of the item and result ports
  localparam int POS_W  = 6;
  localparam int DATA_W = 32;
  localparam int SLOT_W = 5;
  localparam int STAT_W = 2;

  // operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DRAIN  = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BAD_POS   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd3;

  // control state
  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } ise_state_t;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic             ins;
    logic             drain;
    logic [POS_W-1:0] pos;
  } cell_ctrl_t;

endpackage

// ----- rtl/insertion_series_engine_core.sv -----
// Insertion series engine: a bounded list held in a chain of cells. An insert
// (op 0) is accepted at any cycle the block is not busy: the cell at the insert
// position loads the new value and every cell above it its lower neighbor in the
// same clock, so inserts can follow each other back to back, each giving one
// result in the next cycle. A drain (op 1) of N entries shifts the chain down one
// cell per cycle and gives N results on consecutive cycles; the state register
// enters the drain state first and the results are registered from cell 0 after
// it. Busy stays high while the drain runs and a new item can be taken on the
// cycle the final result is shown. A drain of an empty list or a refused insert
// gives one result in the next cycle and keeps busy low. Results appear for one
// cycle under strobe and cannot be held off by the receiver.
module insertion_series_engine_core #(
  parameter int DEPTH      = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                op,
  input  logic [ise_pkg::POS_W-1:0]           position,
  input  logic signed [ise_pkg::DATA_W-1:0]   value,
  output logic                                strobe,
  output logic signed [ise_pkg::DATA_W-1:0]   data,
  output logic [ise_pkg::SLOT_W-1:0]          slot,
  output logic                                last,
  output logic [ise_pkg::STAT_W-1:0]          status
);
  import ise_pkg::*;

  localparam int CW    = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CMP_W = (CW > POS_W) ? CW : POS_W;

  ise_state_t              state;
  ise_state_t              state_next;
  logic [CW-1:0]           count;
  logic [IDX_W-1:0]        idx;
  cell_ctrl_t              ctrl;
  logic [VALUE_BITS-1:0]   ins_val;
  logic [VALUE_BITS-1:0]   cell_val [DEPTH];

  logic take;
  logic take_ins;
  logic take_drain;
  logic bad_pos;
  logic full;
  logic ins_ok;
  logic drain_last;
  logic drain_en;

  // item transfer and insert checks
  assign take       = start && !busy;
  assign take_ins   = take && (op == OP_INSERT);
  assign take_drain = take && (op == OP_DRAIN);
  assign bad_pos    = CMP_W'(position) > CMP_W'(count);
  assign full       = count == CW'(DEPTH);
  assign ins_ok     = take_ins && !bad_pos && !full;
  assign ins_val    = VALUE_BITS'(value);
  assign drain_last = (CW'(idx) + CW'(1)) == count;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (take_drain && (count != '0)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    busy     = 1'b0;
    drain_en = 1'b0;
    unique case (state)
      ST_IDLE: begin
        busy     = 1'b0;
        drain_en = 1'b0;
      end
      ST_DRAIN: begin
        busy     = 1'b1;
        drain_en = 1'b1;
      end
      default: begin
        busy     = 1'b0;
        drain_en = 1'b0;
      end
    endcase
  end

  assign ctrl = '{ins: ins_ok, drain: drain_en, pos: position};

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      count  <= '0;
      idx    <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      // a drain of a filled list reports only from the drain cycles
      strobe <= (take && !(take_drain && (count != '0))) || (state == ST_DRAIN);
      if (ins_ok) begin
        count <= count + CW'(1);
      end else if ((state == ST_DRAIN) && drain_last) begin
        count <= '0;
      end
      if (take_drain) begin
        idx <= '0;
      end else if (state == ST_DRAIN) begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state == ST_DRAIN) begin
      data   <= DATA_W'(cell_val[0]);
      slot   <= SLOT_W'(idx);
      last   <= drain_last;
      status <= STAT_OK;
    end else if (take_drain) begin
      data   <= '0;
      slot   <= '0;
      last   <= 1'b1;
      status <= STAT_EMPTY;
    end else if (take_ins) begin
      last <= 1'b1;
      if (bad_pos) begin
        data   <= value;
        slot   <= '0;
        status <= STAT_BAD_POS;
      end else if (full) begin
        data   <= value;
        slot   <= '0;
        status <= STAT_FULL;
      end else begin
        data   <= DATA_W'(ins_val);
        slot   <= position[SLOT_W-1:0];
        status <= STAT_OK;
      end
    end
  end

  // chain of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VALUE_BITS-1:0] left_v;
    logic [VALUE_BITS-1:0] right_v;

    if (i == 0) begin : g_first
      assign left_v = ins_val;
    end else begin : g_mid_l
      assign left_v = cell_val[i-1];
    end

    if (i == DEPTH - 1) begin : g_end
      assign right_v = cell_val[i];
    end else begin : g_mid_r
      assign right_v = cell_val[i+1];
    end

    ise_cell #(
      .VALUE_BITS (VALUE_BITS),
      .INDEX      (i)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .new_value   (ins_val),
      .left_value  (left_v),
      .right_value (right_v),
      .value       (cell_val[i])
    );
  end

`ifndef NO_ASSERTIONS
  // the list never grows past its capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("list count above capacity");

  // a drain in progress always has entries left to send
  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN) |-> (count != '0))
    else $error("drain running on empty list");

  // the final drained entry leaves the list empty
  a_drain_clears: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_DRAIN) && drain_last) |=> (count == '0) && !busy)
    else $error("list not cleared after drain");

  // refused or empty-drain results are always single and final
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && (status != STAT_OK)) |-> last)
    else $error("error result not marked last");
`endif

endmodule

// ----- rtl/ise_cell.sv -----
// one list cell: holds one entry, shifts up on insert and down on drain
module ise_cell #(
  parameter int VALUE_BITS = 32,
  parameter int INDEX      = 0
) (
  input  logic                    clk,
  input  ise_pkg::cell_ctrl_t     ctrl,
  input  logic [VALUE_BITS-1:0]   new_value,
  input  logic [VALUE_BITS-1:0]   left_value,
  input  logic [VALUE_BITS-1:0]   right_value,
  output logic [VALUE_BITS-1:0]   value
);
  import ise_pkg::*;

  localparam int IDX_BITS = (INDEX > 0) ? $clog2(INDEX + 1) : 1;
  localparam int CMP_W    = (IDX_BITS > POS_W) ? IDX_BITS : POS_W;
  localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(INDEX);

  logic [CMP_W-1:0] pos_ext;

  assign pos_ext = CMP_W'(ctrl.pos);

  // insert: take the new value at the insert point, the left neighbor above it
  // drain: take the right neighbor so cell 0 always holds the next entry out
  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (MY_IDX == pos_ext) begin
        value <= new_value;
      end else if (MY_IDX > pos_ext) begin
        value <= left_value;
      end
    end else if (ctrl.drain) begin
      value <= right_value;
    end
  end

endmodule

// ----- bench/tb_insertion_series_engine_core.sv -----
// self-checking testbench for the insertion series engine core
module tb_insertion_series_engine_core;
  import ise_pkg::*;

  localparam int LIST_DEPTH  = 32;
  localparam int CYCLE_LIMIT = 300000;
  localparam int TAIL_CYCLES = 40;

  // one command to the list and one result from it
  typedef struct {
    logic                     op;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] val;
    int                       gap_pct;
    bit                       hold;
  } list_cmd_t;

  typedef struct {
    logic signed [DATA_W-1:0] data;
    logic [SLOT_W-1:0]        slot;
    logic                     last;
    logic [STAT_W-1:0]        status;
  } list_out_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic                     op = OP_INSERT;
  logic [POS_W-1:0]         position = '0;
  logic signed [DATA_W-1:0] value = '0;
  logic                     strobe;
  logic signed [DATA_W-1:0] data;
  logic [SLOT_W-1:0]        slot;
  logic                     last;
  logic [STAT_W-1:0]        status;

  list_cmd_t pending_cmds[$];
  list_out_t expected_q[$];
  list_cmd_t cur_cmd;

  // list contents as the block should hold them
  logic signed [DATA_W-1:0] model_list [LIST_DEPTH];
  int model_count = 0;

  // occupancy as seen by the stimulus generator
  int gen_count = 0;

  int expected_total = 0;
  int seen_total = 0;
  int errors = 0;
  int cycle_count = 0;
  int phase_start = 0;

  insertion_series_engine_core DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .op(op),
    .position(position),
    .value(value),
    .strobe(strobe),
    .data(data),
    .slot(slot),
    .last(last),
    .status(status)
  );

  always #5 clk = ~clk;

  // cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_insertion_series_engine_core: errors");
      $finish;
    end
  end

  // apply one accepted command to the list copy and queue its results
  task automatic apply_cmd(input list_cmd_t c);
    list_out_t r;
    int i;
    if (c.op == OP_INSERT) begin
      r.data = c.val;
      r.slot = '0;
      r.last = 1'b1;
      if (int'(c.pos) > model_count) begin
        r.status = STAT_BAD_POS;
      end else if (model_count >= LIST_DEPTH) begin
        r.status = STAT_FULL;
      end else begin
        for (i = model_count; i > int'(c.pos); i--) model_list[i] = model_list[i-1];
        model_list[c.pos] = c.val;
        model_count++;
        r.slot = c.pos[SLOT_W-1:0];
        r.status = STAT_OK;
      end
      expected_q.push_back(r);
      expected_total++;
    end else if (model_count == 0) begin
      r.data = '0;
      r.slot = '0;
      r.last = 1'b1;
      r.status = STAT_EMPTY;
      expected_q.push_back(r);
      expected_total++;
    end else begin
      for (i = 0; i < model_count; i++) begin
        r.data = model_list[i];
        r.slot = i[SLOT_W-1:0];
        r.last = (i + 1 == model_count);
        r.status = STAT_OK;
        expected_q.push_back(r);
        expected_total++;
      end
      model_count = 0;
    end
  endtask

  // driver: take commands from the pending queue, one transfer at a time
  always @(posedge clk) begin : drive
    list_cmd_t nxt;
    bit go;
    if (rst) begin
      start <= 1'b0;
    end else begin
      go = 1'b0;
      if (start && !busy) apply_cmd(cur_cmd);
      if (start && busy) begin
        go = 1'b1;
      end else if (pending_cmds.size() > 0) begin
        nxt = pending_cmds[0];
        if (!(nxt.hold && expected_total != seen_total) &&
            $urandom_range(99) >= nxt.gap_pct) begin
          void'(pending_cmds.pop_front());
          cur_cmd = nxt;
          go = 1'b1;
          op <= nxt.op;
          position <= nxt.pos;
          value <= nxt.val;
        end
      end
      start <= go;
    end
  end

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  // monitor: every strobed result against the oldest expectation
  always @(posedge clk) begin : check
    list_out_t w;
    if (!rst && strobe === 1'b1) begin
      seen_total <= seen_total + 1;
      if (expected_q.size() == 0) begin
        flag_error($sformatf("unexpected result data=%h slot=%0d last=%b status=%0d",
                             data, slot, last, status));
      end else begin
        w = expected_q.pop_front();
        if (data !== w.data || slot !== w.slot || last !== w.last ||
            status !== w.status) begin
          flag_error({$sformatf("mismatch: expected data=%h slot=%0d last=%b status=%0d",
                                w.data, w.slot, w.last, w.status),
                      $sformatf(", got data=%h slot=%0d last=%b status=%0d",
                                data, slot, last, status)});
        end
      end
    end
  end

  // append one command and track the occupancy it leaves behind
  task automatic add_cmd(input logic o, input int p, input logic [DATA_W-1:0] v,
                         input int gap, input bit hold);
    list_cmd_t c;
    c.op = o;
    c.pos = p[POS_W-1:0];
    c.val = v;
    c.gap_pct = gap;
    c.hold = hold;
    pending_cmds.push_back(c);
    if (o == OP_DRAIN) gen_count = 0;
    else if (p <= gen_count && gen_count < LIST_DEPTH) gen_count++;
  endtask

  function automatic logic [DATA_W-1:0] rand_value();
    case ($urandom_range(7))
      0: rand_value = 32'h8000_0000;
      1: rand_value = 32'h7fff_ffff;
      2: rand_value = 32'hffff_ffff;
      3: rand_value = 32'h0000_0000;
      default: rand_value = $urandom;
    endcase
  endfunction

  // insert position: mostly legal, now and then past the count
  function automatic int rand_pos();
    if ($urandom_range(7) == 0 && gen_count < 63) begin
      rand_pos = $urandom_range(63, gen_count + 1);
    end else begin
      rand_pos = $urandom_range(gen_count);
    end
  endfunction

  // random traffic: list builds ending in a drain, fills to full, and noise
  task automatic run_phase(input int gap, input int n_items);
    int made;
    int kind;
    int len;
    int k;
    made = 0;
    kind = 6;
    while (made < n_items) begin
      if (kind < 6) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(32, 9) : $urandom_range(6, 1);
        for (k = 0; k < len; k++) begin
          add_cmd(OP_INSERT, rand_pos(), rand_value(), gap, 1'b0);
        end
        add_cmd(OP_DRAIN, $urandom_range(63), $urandom, gap, $urandom_range(9) == 0);
        made += len + 1;
      end else if (kind < 8) begin
        while (gen_count < LIST_DEPTH) begin
          add_cmd(OP_INSERT, $urandom_range(gen_count), rand_value(), gap, 1'b0);
          made++;
        end
        // refused inserts into the full list, some past the count as well
        for (k = 0; k < 3; k++) begin
          add_cmd(OP_INSERT, $urandom_range(34, 30), rand_value(), gap, 1'b0);
        end
        add_cmd(OP_DRAIN, 0, 0, gap, 1'b0);
        made += 4;
      end else begin
        for (k = 0; k < 4; k++) begin
          add_cmd(1'($urandom_range(1)), $urandom_range(63), $urandom, gap, 1'b0);
        end
        made += 4;
      end
      kind = $urandom_range(9);
    end
  endtask

  // stimulus and end of run
  initial begin
    // directed: empty drain, bad positions, value extremes, short drains
    add_cmd(OP_DRAIN, 0, 0, 0, 1'b0);
    add_cmd(OP_INSERT, 1, 32'h1234_5678, 0, 1'b0);
    add_cmd(OP_INSERT, 63, 32'h7fff_ffff, 0, 1'b0);
    add_cmd(OP_INSERT, 0, 32'h8000_0000, 0, 1'b0);
    add_cmd(OP_INSERT, 1, 32'h7fff_ffff, 0, 1'b0);
    add_cmd(OP_INSERT, 0, 32'hffff_ffff, 0, 1'b0);
    add_cmd(OP_INSERT, 1, 32'h0000_0000, 0, 1'b0);
    add_cmd(OP_INSERT, 5, 32'hdead_beef, 0, 1'b0);
    add_cmd(OP_INSERT, 4, 32'h5555_5555, 0, 1'b0);
    add_cmd(OP_INSERT, 2, 32'haaaa_aaaa, 0, 1'b0);
    add_cmd(OP_DRAIN, 63, 32'hffff_ffff, 0, 1'b0);
    add_cmd(OP_DRAIN, 0, 0, 0, 1'b0);
    add_cmd(OP_INSERT, 0, 32'h0000_0001, 0, 1'b0);
    add_cmd(OP_DRAIN, 0, 0, 0, 1'b0);
    add_cmd(OP_INSERT, 0, 32'h0000_0002, 0, 1'b0);
    add_cmd(OP_INSERT, 0, 32'h0000_0003, 0, 1'b0);
    add_cmd(OP_DRAIN, 0, 0, 0, 1'b1);

    run_phase(0, 150);
    phase_start = pending_cmds.size();
    run_phase(58, 150);
    // pause for every outstanding result before the idle phases start
    pending_cmds[phase_start].hold = 1'b1;
    run_phase(10, 130);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() != 0 || start) @(posedge clk);
    while (expected_total != seen_total) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0 && expected_q.size() == 0) begin
      $display("tb_insertion_series_engine_core: clean");
    end else begin
      $display("tb_insertion_series_engine_core: errors");
    end
    $finish;
  end

endmodule
